FILE: rtl/two_stack_fifo_queue_unit_assert.svh
// Assertion macros shared by the two-stack queue checker
`ifndef TWO_STACK_FIFO_QUEUE_UNIT_ASSERT_SVH
`define TWO_STACK_FIFO_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TSQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TSQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tsq_pkg.sv
// Package for the two-stack queue: sizes, codes and controller/datapath types
package tsq_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [PTR_W-1:0]  ptr_t;

    localparam cnt_t  CNT_ZERO   = cnt_t'(0);
    localparam cnt_t  CNT_ONE    = cnt_t'(1);
    localparam cnt_t  CNT_FULL   = cnt_t'(STACK_DEPTH);
    localparam word_t EMPTY_DATA = '1;
    localparam word_t ZERO_DATA  = '0;

    // Request kind carried on tuser
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Result status carried on tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_POP,
        S_DONE
    } state_t;

    // Which result the output register takes
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FULL,
        RES_EMPTY,
        RES_POP
    } res_sel_t;

    typedef struct packed {
        logic     push;      // write value on inbound top
        logic     pop;       // read outbound top, count down
        logic     move_rd;   // read inbound top for a transfer
        logic     out_load;  // load the output register
        res_sel_t res_sel;
    } tsq_cmd_t;

    typedef struct packed {
        logic in_empty;
        logic in_full;
        logic out_empty;
        logic move_pend;     // a transfer write is in flight
        logic out_free;      // output register can take a result
    } tsq_sts_t;

endpackage

FILE: rtl/tsq_ram.sv
// Generic single-write, single-read RAM with registered read data
module tsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read ports; read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/tsq_datapath.sv
// Datapath: both stacks, their counts and the output register
module tsq_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  tsq_pkg::tsq_cmd_t cmd,
    output tsq_pkg::tsq_sts_t sts,
    input  tsq_pkg::word_t    s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output tsq_pkg::word_t    m_tdata,
    output tsq_pkg::status_t  m_tuser
);
    import tsq_pkg::*;

    cnt_t    in_cnt_reg, in_cnt_next;
    cnt_t    out_cnt_reg, out_cnt_next;
    logic    move_pend_reg, move_pend_next;
    logic    m_tvalid_reg, m_tvalid_next;
    word_t   m_tdata_reg, m_tdata_next;
    status_t m_tuser_reg, m_tuser_next;
    cnt_t    in_dec, out_dec;
    word_t   in_rd_data, out_rd_data;

    assign in_dec  = in_cnt_reg - CNT_ONE;
    assign out_dec = out_cnt_reg - CNT_ONE;

    // Inbound stack: push on enqueue, read top during a transfer
    tsq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_in_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (in_cnt_reg[PTR_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (cmd.move_rd),
        .rd_addr (in_dec[PTR_W-1:0]),
        .rd_data (in_rd_data)
    );

    // Outbound stack: filled by transfer writes, popped on dequeue
    tsq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_out_ram (
        .clk     (clk),
        .wr_en   (move_pend_reg),
        .wr_addr (out_cnt_reg[PTR_W-1:0]),
        .wr_data (in_rd_data),
        .rd_en   (cmd.pop),
        .rd_addr (out_dec[PTR_W-1:0]),
        .rd_data (out_rd_data)
    );

    // Stack counts; a transfer read is written across in the cycle after it
    always_comb
    begin
        in_cnt_next    = in_cnt_reg;
        out_cnt_next   = out_cnt_reg;
        move_pend_next = cmd.move_rd;
        if (cmd.push)
        begin
            in_cnt_next = in_cnt_reg + CNT_ONE;
        end
        else if (cmd.move_rd)
        begin
            in_cnt_next = in_dec;
        end
        if (cmd.pop)
        begin
            out_cnt_next = out_dec;
        end
        else if (move_pend_reg)
        begin
            out_cnt_next = out_cnt_reg + CNT_ONE;
        end
    end

    // Result select and output register
    always_comb
    begin
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
            unique case (cmd.res_sel)
                RES_ZERO:
                begin
                    m_tdata_next = ZERO_DATA;
                    m_tuser_next = ST_OK;
                end
                RES_FULL:
                begin
                    m_tdata_next = ZERO_DATA;
                    m_tuser_next = ST_FULL;
                end
                RES_EMPTY:
                begin
                    m_tdata_next = EMPTY_DATA;
                    m_tuser_next = ST_EMPTY;
                end
                RES_POP:
                begin
                    m_tdata_next = out_rd_data;
                    m_tuser_next = ST_OK;
                end
                default:
                begin
                    m_tdata_next = ZERO_DATA;
                    m_tuser_next = ST_OK;
                end
            endcase
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg    <= CNT_ZERO;
            out_cnt_reg   <= CNT_ZERO;
            move_pend_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            move_pend_reg <= move_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign sts.in_empty  = (in_cnt_reg == CNT_ZERO);
    assign sts.in_full   = (in_cnt_reg == CNT_FULL);
    assign sts.out_empty = (out_cnt_reg == CNT_ZERO);
    assign sts.move_pend = move_pend_reg;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/tsq_ctrl.sv
// Controller: sequences enqueue, dequeue, stack transfer and result hand-off
module tsq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    input  tsq_pkg::tsq_sts_t sts,
    output tsq_pkg::tsq_cmd_t cmd
);
    import tsq_pkg::*;

    state_t   state_reg, state_next;
    res_sel_t res_sel_reg, res_sel_next;

    // Next state and pending result kind
    always_comb
    begin
        state_next   = state_reg;
        res_sel_next = res_sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == OP_DEQUEUE)
                    begin
                        if (!sts.out_empty)
                        begin
                            state_next   = S_DONE;
                            res_sel_next = RES_POP;
                        end
                        else if (!sts.in_empty)
                        begin
                            state_next = S_MOVE;
                        end
                        else
                        begin
                            state_next   = S_DONE;
                            res_sel_next = RES_EMPTY;
                        end
                    end
                    else
                    begin
                        state_next   = S_DONE;
                        res_sel_next = sts.in_full ? RES_FULL : RES_ZERO;
                    end
                end
            end
            S_MOVE:
            begin
                // done once inbound is drained and the last write has landed
                if (sts.in_empty && !sts.move_pend)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                state_next   = S_DONE;
                res_sel_next = RES_POP;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.res_sel  = res_sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == OP_DEQUEUE)
                    begin
                        cmd.pop = !sts.out_empty;
                    end
                    else
                    begin
                        cmd.push = !sts.in_full;
                    end
                end
            end
            S_MOVE:
            begin
                cmd.move_rd = !sts.in_empty;
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            res_sel_reg <= RES_ZERO;
        end
        else
        begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
        end
    end

endmodule

FILE: rtl/two_stack_fifo_queue_unit.sv
// Top level of the two-stack FIFO queue
//
// Requests enter on the s_ group: s_tuser is the kind (enqueue or dequeue),
// s_tdata the value to enqueue. Every request gives one result on the m_
// group: m_tdata the dequeued entry (all ones if the queue is empty, zero on
// any enqueue), m_tuser the status (ok, empty, inbound full).
// One request is worked on at a time. An enqueue, and a dequeue that finds
// data on the outbound stack, go straight to the hand-off state and load
// the result there; the next request is taken back in idle. A dequeue that
// finds the outbound stack empty first moves all n inbound entries across,
// one per cycle through the inbound RAM read port, then passes through the
// pop and hand-off states before loading its result.
// An enqueue into a full inbound stack is dropped and reports full.
// Reset empties both stacks by clearing their counts; the RAMs are not swept.
// If the receiver stalls, the result holds in the output register and the
// controller waits in its hand-off state, so s_tready stays low until the
// result leaves or is taken in the same cycle.
module two_stack_fifo_queue_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  tsq_pkg::word_t   s_tdata,   // [31:0] value
    input  logic             s_tuser,   // [0] opcode
    output logic             m_tvalid,
    input  logic             m_tready,
    output tsq_pkg::word_t   m_tdata,   // [31:0] data
    output tsq_pkg::status_t m_tuser    // [1:0] status
);
    import tsq_pkg::*;

    tsq_cmd_t cmd;
    tsq_sts_t sts;

    tsq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/tsq_checker.sv
// Port-level checks for the two-stack queue, bound to the top level
`include "two_stack_fifo_queue_unit_assert.svh"

module tsq_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input tsq_pkg::word_t   m_tdata,
    input tsq_pkg::status_t m_tuser
);
    import tsq_pkg::*;

    // A stalled result holds
    `TSQ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // One request at a time: no request taken right after another
    `TSQ_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "back-to-back request accepted")

    // Empty result carries all ones
    `TSQ_ASSERT_IMP(a_empty_data, m_tvalid && (m_tuser == ST_EMPTY), m_tdata == EMPTY_DATA, "empty result data not all ones")

    // Only defined status codes appear
    `TSQ_ASSERT_IMP(a_status_code, m_tvalid, (m_tuser == ST_OK) || (m_tuser == ST_EMPTY) || (m_tuser == ST_FULL), "undefined status code")

    // Full result carries zero data
    `TSQ_ASSERT_IMP(a_full_data, m_tvalid && (m_tuser == ST_FULL), m_tdata == ZERO_DATA, "full result data not zero")

endmodule

bind two_stack_fifo_queue_unit tsq_checker u_tsq_checker (.*);

FILE: tb/two_stack_fifo_queue_unit_test.sv
// Self-checking testbench for the two-stack FIFO queue with random idling on both streams
module two_stack_fifo_queue_unit_test;

    import tsq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = STACK_DEPTH + 20;

    typedef struct {
        word_t   data;
        status_t status;
    } queue_result_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    s_tvalid;
    logic    s_tready;
    word_t   s_tdata;   // [31:0] value
    logic    s_tuser;   // [0] opcode
    logic    m_tvalid;
    logic    m_tready;
    word_t   m_tdata;   // [31:0] data
    status_t m_tuser;   // [1:0] status

    // Queue model state
    word_t model_inbound [STACK_DEPTH];
    word_t model_outbound[STACK_DEPTH];
    int    inbound_fill;
    int    outbound_fill;

    queue_result_t pending_results[$];
    queue_result_t oldest_result;
    int            failures        = 0;
    int            cycle_count     = 0;
    int            tx_max_gap      = 8;
    int            rx_max_gap      = 8;
    int            hold_off_cycles = 0;

    two_stack_fifo_queue_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("two_stack_fifo_queue_unit_test: FAIL");
            $finish;
        end
    end

    // Queue model: works out the result of one accepted request
    function automatic void predict_queue_result(input logic op, input word_t value);
        queue_result_t res;
        res.data   = ZERO_DATA;
        res.status = ST_OK;
        if (op == OP_DEQUEUE)
        begin
            if (inbound_fill == 0 && outbound_fill == 0)
            begin
                res.data   = EMPTY_DATA;
                res.status = ST_EMPTY;
            end
            else
            begin
                // refill outbound from inbound, top first
                if (outbound_fill == 0)
                begin
                    while (inbound_fill > 0 && outbound_fill < STACK_DEPTH)
                    begin
                        inbound_fill--;
                        model_outbound[outbound_fill] = model_inbound[inbound_fill];
                        outbound_fill++;
                    end
                end
                outbound_fill--;
                res.data = model_outbound[outbound_fill];
            end
        end
        else if (inbound_fill >= STACK_DEPTH)
        begin
            res.status = ST_FULL;
        end
        else
        begin
            model_inbound[inbound_fill] = value;
            inbound_fill++;
        end
        pending_results.push_back(res);
    endfunction

    // Offer one request, wait for it to be taken, then predict its result
    task automatic send_request(input logic op, input word_t value);
        int gap;
        gap = (tx_max_gap > 0) ? $urandom_range(tx_max_gap, 0) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        predict_queue_result(op, value);
    endtask

    function automatic word_t random_value();
        case ($urandom_range(15, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return word_t'($urandom());
        endcase
    endfunction

    // Result receiver: random stall per result, long hold-off on request
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
            begin
                stall = (rx_max_gap > 0) ? $urandom_range(rx_max_gap, 0) : 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(negedge clk); while (!m_tvalid);
            @(posedge clk);
        end
    end

    // Result checker: sampled mid-cycle, ahead of the accepting edge
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: data %h status %0d", m_tdata, m_tuser);
                failures++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (m_tdata !== oldest_result.data)
                begin
                    $error("data: expected %h, actual %h", oldest_result.data, m_tdata);
                    failures++;
                end
                if (m_tuser !== oldest_result.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           oldest_result.status, m_tuser);
                    failures++;
                end
            end
        end
    end

    // Extremes, empty dequeue, order reversal across a refill
    task automatic test_directed();
        send_request(OP_DEQUEUE, 32'h1234_5678);
        send_request(OP_ENQUEUE, 32'h8000_0000);
        send_request(OP_ENQUEUE, 32'h7fff_ffff);
        send_request(OP_ENQUEUE, 32'h0000_0000);
        send_request(OP_ENQUEUE, 32'hffff_ffff);
        send_request(OP_ENQUEUE, 32'h0000_0001);
        send_request(OP_DEQUEUE, 32'hffff_ffff);
        send_request(OP_DEQUEUE, 32'h0000_0000);
        send_request(OP_ENQUEUE, 32'ha5a5_a5a5);
        send_request(OP_ENQUEUE, 32'h5a5a_5a5a);
        repeat (5) send_request(OP_DEQUEUE, 32'h8000_0000);
        send_request(OP_DEQUEUE, 32'hffff_ffff);
    endtask

    // Full refill, inbound overflow while outbound has room, full drain
    task automatic test_overflow();
        repeat (STACK_DEPTH) send_request(OP_ENQUEUE, random_value());
        send_request(OP_DEQUEUE, random_value());
        repeat (STACK_DEPTH) send_request(OP_ENQUEUE, random_value());
        repeat (3) send_request(OP_ENQUEUE, random_value());
        send_request(OP_DEQUEUE, random_value());
        send_request(OP_ENQUEUE, random_value());
        repeat (2 * STACK_DEPTH) send_request(OP_DEQUEUE, random_value());
    endtask

    // Receiver holds off while requests keep coming
    task automatic test_backpressure();
        tx_max_gap = 0;
        hold_off_cycles = 200;
        repeat (30)
            send_request(($urandom_range(2, 0) == 0) ? OP_DEQUEUE : OP_ENQUEUE,
                         random_value());
        tx_max_gap = 8;
    endtask

    // Bursts with a drifting enqueue share and changing idle settings
    task automatic test_random(input int num_requests);
        int sent;
        int burst;
        int enq_pct;
        sent = 0;
        while (sent < num_requests)
        begin
            case ($urandom_range(3, 0))
                0:       enq_pct = 25;
                1:       enq_pct = 50;
                2:       enq_pct = 75;
                default: enq_pct = 95;
            endcase
            case ($urandom_range(3, 0))
                0:       begin tx_max_gap = 0; rx_max_gap = 0; end
                1:       begin tx_max_gap = 8; rx_max_gap = 0; end
                2:       begin tx_max_gap = 0; rx_max_gap = 8; end
                default: begin tx_max_gap = 8; rx_max_gap = 8; end
            endcase
            burst = $urandom_range(60, 20);
            repeat (burst)
            begin
                send_request(($urandom_range(99, 0) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                             random_value());
                sent++;
            end
        end
        tx_max_gap = 8;
        rx_max_gap = 8;
    endtask

    initial
    begin
        inbound_fill  = 0;
        outbound_fill = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_ENQUEUE;
        s_tdata  <= ZERO_DATA;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow();
        test_backpressure();
        test_random(880);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("two_stack_fifo_queue_unit_test: PASS");
        else
            $display("two_stack_fifo_queue_unit_test: FAIL");
        $finish;
    end

endmodule
